FILE: src/dhoat_pkg.sv
// shared constants for the double hashing open address table
package dhoat_pkg;

  localparam int WORD_W     = 32;
  localparam int OPCODE_W   = 2;
  localparam int STATUS_W   = 3;
  localparam int SLOT_IDX_W = 10;
  localparam int OCC_W      = 11;
  localparam int CFG_W      = 11;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_USED    = 2'd1;
  localparam logic [1:0] MARK_VACATED = 2'd2;

endpackage

FILE: src/dhoat_modunit.sv
// bit serial remainder unit, one dividend bit per cycle
module dhoat_modunit #(
  parameter int DW = 32,
  parameter int RW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [RW-1:0] divisor,
  output logic          done,
  output logic [RW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dvd;
  logic [RW:0]   trial;
  logic [RW:0]   diff;
  logic [RW-1:0] rem_next;

  assign trial    = {rem, dvd[DW-1]};
  assign diff     = trial - {1'b0, divisor};
  assign rem_next = (trial >= {1'b0, divisor}) ? diff[RW-1:0] : trial[RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= dvd << 1;
    end
  end

endmodule

FILE: src/double_hash_open_address_table.sv
// slot table with double hashing probe walk over block memories
// sequence: table full or an unknown opcode goes straight to the result; otherwise
//   serial remainders (hash1 mod p, hash2 mod p), then a read and a check per probe, then finish
// throughput: one word at a time, next word taken once the result is registered
// reset: synchronous; the slot marks are swept to empty, one slot a cycle,
//   and the first word is taken once the sweep is done
module double_hash_open_address_table #(
  parameter int SLOTS      = 1024,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dhoat_pkg::OPCODE_W-1:0]     opcode,
  input  logic [dhoat_pkg::WORD_W-1:0]       key,
  input  logic [dhoat_pkg::WORD_W-1:0]       value,
  input  logic [dhoat_pkg::WORD_W-1:0]       hash1,
  input  logic [dhoat_pkg::WORD_W-1:0]       hash2,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dhoat_pkg::STATUS_W-1:0]     status,
  output logic [dhoat_pkg::WORD_W-1:0]       found_value,
  output logic [dhoat_pkg::SLOT_IDX_W-1:0]   slot_index,
  output logic [dhoat_pkg::OCC_W-1:0]        occupancy,
  input  logic                               cfg_we,
  input  logic [dhoat_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int AW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam int EW = (PW > dhoat_pkg::CFG_W) ? PW : dhoat_pkg::CFG_W;
  localparam int KW = (KEY_BITS < dhoat_pkg::WORD_W) ? KEY_BITS : dhoat_pkg::WORD_W;
  localparam int VW = (VALUE_BITS < dhoat_pkg::WORD_W) ? VALUE_BITS : dhoat_pkg::WORD_W;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_MOD1   = 8'b0000_0100,
    S_MOD2   = 8'b0000_1000,
    S_READ   = 8'b0001_0000,
    S_CHECK  = 8'b0010_0000,
    S_FINISH = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state;

  logic [dhoat_pkg::CFG_W-1:0] positions_in_use;
  logic [EW-1:0]               cfg_ext;
  logic [PW-1:0]               p_eff;

  logic [dhoat_pkg::OPCODE_W-1:0] op;
  logic [KW-1:0]                  key_r;
  logic [VW-1:0]                  val_r;
  logic [dhoat_pkg::WORD_W-1:0]   h2_r;
  logic [PW-1:0]                  p_r;
  logic [AW-1:0]                  pos;
  logic [AW-1:0]                  step;
  logic [PW-1:0]                  probe_cnt;
  logic                           free_found;
  logic [AW-1:0]                  free_pos;
  logic                           hit;
  logic [PW-1:0]                  count;

  logic [dhoat_pkg::STATUS_W-1:0] res_status;
  logic [VW-1:0]                  res_found;
  logic [AW-1:0]                  res_slot;

  logic [1:0]    marks [SLOTS];
  logic [KW-1:0] keys  [SLOTS];
  logic [VW-1:0] vals  [SLOTS];
  logic [1:0]    rd_mark;
  logic [KW-1:0] rd_key;
  logic [VW-1:0] rd_val;

  logic [AW-1:0] clr_addr;
  logic          mark_we;
  logic [1:0]    mark_wdata;
  logic [AW-1:0] wr_addr;
  logic          kv_we;

  logic          accept;
  logic          div_start;
  logic [dhoat_pkg::WORD_W-1:0] div_dividend;
  logic          div_done;
  logic [PW-1:0] div_rem;

  logic [AW:0]   pos_sum;
  logic [AW:0]   pos_wrap;
  logic [AW-1:0] pos_next;
  logic [PW-1:0] probe_cnt_next;
  logic          ins_ok;

  // effective probing range, 0 acts as 1 and large values clamp to SLOTS
  assign cfg_ext = EW'(positions_in_use);
  always_comb begin
    priority if (positions_in_use == '0) begin
      p_eff = PW'(1);
    end else if (cfg_ext > EW'(SLOTS)) begin
      p_eff = PW'(SLOTS);
    end else begin
      p_eff = PW'(cfg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      positions_in_use <= dhoat_pkg::CFG_RESET;
    end else if (cfg_we) begin
      positions_in_use <= cfg_wdata;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign div_start = (accept && (opcode != dhoat_pkg::OP_INSERT || count < p_eff)
                      && opcode != dhoat_pkg::OP_UNUSED)
                     || (state == S_MOD1 && div_done);
  assign div_dividend = (state == S_IDLE) ? hash1 : h2_r;

  dhoat_modunit #(
    .DW(dhoat_pkg::WORD_W),
    .RW(PW)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor ((state == S_IDLE) ? p_eff : p_r),
    .done    (div_done),
    .rem     (div_rem)
  );

  // next probe position
  assign pos_sum        = {1'b0, pos} + {1'b0, step};
  assign pos_wrap       = pos_sum - (AW + 1)'(p_r);
  assign pos_next       = (pos_sum >= (AW + 1)'(p_r)) ? pos_wrap[AW-1:0] : pos_sum[AW-1:0];
  assign probe_cnt_next = probe_cnt + 1'b1;

  assign ins_ok = (op == dhoat_pkg::OP_INSERT) && !hit && free_found;

  // slot memory writes
  always_comb begin
    mark_we    = 1'b0;
    mark_wdata = dhoat_pkg::MARK_EMPTY;
    wr_addr    = pos;
    kv_we      = 1'b0;
    priority if (state == S_CLEAR) begin
      mark_we = 1'b1;
      wr_addr = clr_addr;
    end else if (state == S_FINISH && ins_ok) begin
      mark_we    = 1'b1;
      mark_wdata = dhoat_pkg::MARK_USED;
      wr_addr    = free_pos;
      kv_we      = 1'b1;
    end else if (state == S_FINISH && op == dhoat_pkg::OP_REMOVE && hit) begin
      mark_we    = 1'b1;
      mark_wdata = dhoat_pkg::MARK_VACATED;
    end else begin
      mark_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      marks[wr_addr] <= mark_wdata;
    end
    rd_mark <= marks[pos];
  end

  always_ff @(posedge clk) begin
    if (kv_we) begin
      keys[wr_addr] <= key_r;
    end
    rd_key <= keys[pos];
  end

  always_ff @(posedge clk) begin
    if (kv_we) begin
      vals[wr_addr] <= val_r;
    end
    rd_val <= vals[pos];
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (div_start) begin
              state <= S_MOD1;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_MOD1: begin
          if (div_done) begin
            state <= S_MOD2;
          end
        end
        S_MOD2: begin
          if (div_done) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (rd_mark == dhoat_pkg::MARK_EMPTY
              || (rd_mark == dhoat_pkg::MARK_USED && rd_key == key_r)
              || probe_cnt_next == p_r) begin
            state <= S_FINISH;
          end else begin
            state <= S_READ;
          end
        end
        S_FINISH: begin
          if (ins_ok) begin
            count <= count + 1'b1;
          end else if (op == dhoat_pkg::OP_REMOVE && hit && count != '0) begin
            count <= count - 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op         <= opcode;
        key_r      <= key[KW-1:0];
        val_r      <= value[VW-1:0];
        h2_r       <= hash2;
        p_r        <= p_eff;
        res_found  <= '0;
        res_slot   <= '0;
        res_status <= (opcode == dhoat_pkg::OP_INSERT) ? dhoat_pkg::ST_FULL
                                                        : dhoat_pkg::ST_NOTFOUND;
      end
      S_MOD1: begin
        if (div_done) begin
          pos <= AW'(div_rem);
        end
      end
      S_MOD2: begin
        if (div_done) begin
          step <= AW'(div_rem);
        end
        probe_cnt  <= '0;
        free_found <= 1'b0;
        hit        <= 1'b0;
      end
      S_CHECK: begin
        if (rd_mark != dhoat_pkg::MARK_USED && !free_found) begin
          free_found <= 1'b1;
          free_pos   <= pos;
        end
        if (rd_mark == dhoat_pkg::MARK_USED && rd_key == key_r) begin
          hit <= 1'b1;
        end else if (rd_mark != dhoat_pkg::MARK_EMPTY) begin
          probe_cnt <= probe_cnt_next;
          if (probe_cnt_next != p_r) begin
            pos <= pos_next;
          end
        end
      end
      S_FINISH: begin
        unique case (op)
          dhoat_pkg::OP_INSERT: begin
            if (hit) begin
              res_status <= dhoat_pkg::ST_PRESENT;
            end else if (free_found) begin
              res_status <= dhoat_pkg::ST_DONE;
              res_slot   <= free_pos;
            end else begin
              res_status <= dhoat_pkg::ST_EXHAUSTED;
            end
          end
          dhoat_pkg::OP_REMOVE, dhoat_pkg::OP_LOOKUP: begin
            if (hit) begin
              res_status <= dhoat_pkg::ST_DONE;
              res_found  <= rd_val;
              res_slot   <= pos;
            end else begin
              res_status <= dhoat_pkg::ST_NOTFOUND;
            end
          end
          default: begin
            res_status <= dhoat_pkg::ST_NOTFOUND;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          status      <= res_status;
          found_value <= dhoat_pkg::WORD_W'(res_found);
          slot_index  <= dhoat_pkg::SLOT_IDX_W'(res_slot);
          occupancy   <= dhoat_pkg::OCC_W'(count);
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> (PW'(pos) < p_r && PW'(step) < p_r))
    else $error("probe position outside the active range");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (div_done && state == S_MOD1) |-> div_rem < p_r)
    else $error("remainder not below divisor");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && ins_ok) |=> count == $past(count) + 1'b1)
    else $error("insert did not bump the count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= PW'(SLOTS))
    else $error("count above slot total");

  a_done_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_status == dhoat_pkg::ST_DONE) |-> PW'(res_slot) < p_r)
    else $error("reported slot outside the active range");
`endif

endmodule

FILE: verif/tb.sv
// testbench for double_hash_open_address_table: random and directed requests against a shadow table
`timescale 1ns / 100ps

module tb;

  localparam int SLOT_CNT = 1024;
  localparam int POOL_N = 32;
  localparam int PHASES = 16;
  localparam int PHASE_WORDS = 95;

  typedef struct packed {
    logic [dhoat_pkg::OPCODE_W-1:0] op;
    logic [dhoat_pkg::WORD_W-1:0]   k;
    logic [dhoat_pkg::WORD_W-1:0]   v;
    logic [dhoat_pkg::WORD_W-1:0]   h1;
    logic [dhoat_pkg::WORD_W-1:0]   h2;
  } table_req_t;

  typedef struct packed {
    logic [dhoat_pkg::STATUS_W-1:0]   status;
    logic [dhoat_pkg::WORD_W-1:0]     found;
    logic [dhoat_pkg::SLOT_IDX_W-1:0] slot;
    logic [dhoat_pkg::OCC_W-1:0]      occ;
  } table_answer_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [dhoat_pkg::OPCODE_W-1:0] opcode = '0;
  logic [dhoat_pkg::WORD_W-1:0] key = '0;
  logic [dhoat_pkg::WORD_W-1:0] value = '0;
  logic [dhoat_pkg::WORD_W-1:0] hash1 = '0;
  logic [dhoat_pkg::WORD_W-1:0] hash2 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [dhoat_pkg::STATUS_W-1:0] status;
  logic [dhoat_pkg::WORD_W-1:0] found_value;
  logic [dhoat_pkg::SLOT_IDX_W-1:0] slot_index;
  logic [dhoat_pkg::OCC_W-1:0] occupancy;
  logic cfg_we = 1'b0;
  logic [dhoat_pkg::CFG_W-1:0] cfg_wdata = '0;

  table_req_t requests_q[$];
  table_answer_t answers_due[$];
  int unsigned words_issued = 0;
  int unsigned words_taken = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned answers_seen = 0;
  bit quiet = 1'b0;

  logic [dhoat_pkg::WORD_W-1:0] shadow_key[SLOT_CNT];
  logic [dhoat_pkg::WORD_W-1:0] shadow_val[SLOT_CNT];
  logic [1:0] shadow_mark[SLOT_CNT];
  int unsigned shadow_fill = 0;
  logic [dhoat_pkg::CFG_W-1:0] span_reg = dhoat_pkg::CFG_RESET;

  logic [dhoat_pkg::WORD_W-1:0] pool_key[POOL_N];
  logic [dhoat_pkg::WORD_W-1:0] pool_h1[POOL_N];
  logic [dhoat_pkg::WORD_W-1:0] pool_h2[POOL_N];

  double_hash_open_address_table u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .key(key),
    .value(value),
    .hash1(hash1),
    .hash2(hash2),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .found_value(found_value),
    .slot_index(slot_index),
    .occupancy(occupancy),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < SLOT_CNT; i++) shadow_mark[i] = dhoat_pkg::MARK_EMPTY;
  end

  function automatic int unsigned clamp_span(input logic [dhoat_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > SLOT_CNT) return SLOT_CNT;
    return v;
  endfunction

  function automatic bit seek_key(input logic [dhoat_pkg::WORD_W-1:0] k, h1, h2,
                                  output int unsigned at);
    int unsigned p, pos, step;
    p = clamp_span(span_reg);
    pos = h1 % p;
    step = h2 % p;
    at = 0;
    for (int unsigned i = 0; i < p; i++) begin
      if (shadow_mark[pos] == dhoat_pkg::MARK_EMPTY) return 1'b0;
      if (shadow_mark[pos] == dhoat_pkg::MARK_USED && shadow_key[pos] == k) begin
        at = pos;
        return 1'b1;
      end
      pos += step;
      if (pos >= p) pos -= p;
    end
    return 1'b0;
  endfunction

  function automatic table_answer_t table_answer(input table_req_t t);
    table_answer_t r;
    int unsigned p, pos, step, at;
    bit placed;
    r.status = dhoat_pkg::ST_NOTFOUND;
    r.found = '0;
    r.slot = '0;
    at = 0;
    placed = 1'b0;
    p = clamp_span(span_reg);
    case (t.op)
      dhoat_pkg::OP_INSERT: begin
        if (shadow_fill >= p) begin
          r.status = dhoat_pkg::ST_FULL;
        end else if (seek_key(t.k, t.h1, t.h2, at)) begin
          r.status = dhoat_pkg::ST_PRESENT;
        end else begin
          pos = t.h1 % p;
          step = t.h2 % p;
          r.status = dhoat_pkg::ST_EXHAUSTED;
          for (int unsigned i = 0; i < p && !placed; i++) begin
            if (shadow_mark[pos] != dhoat_pkg::MARK_USED) begin
              shadow_key[pos] = t.k;
              shadow_val[pos] = t.v;
              shadow_mark[pos] = dhoat_pkg::MARK_USED;
              shadow_fill++;
              r.status = dhoat_pkg::ST_DONE;
              r.slot = pos[dhoat_pkg::SLOT_IDX_W-1:0];
              placed = 1'b1;
            end else begin
              pos += step;
              if (pos >= p) pos -= p;
            end
          end
        end
      end
      dhoat_pkg::OP_REMOVE: begin
        if (seek_key(t.k, t.h1, t.h2, at)) begin
          r.found = shadow_val[at];
          shadow_mark[at] = dhoat_pkg::MARK_VACATED;
          if (shadow_fill > 0) shadow_fill--;
          r.status = dhoat_pkg::ST_DONE;
          r.slot = at[dhoat_pkg::SLOT_IDX_W-1:0];
        end
      end
      dhoat_pkg::OP_LOOKUP: begin
        if (seek_key(t.k, t.h1, t.h2, at)) begin
          r.found = shadow_val[at];
          r.status = dhoat_pkg::ST_DONE;
          r.slot = at[dhoat_pkg::SLOT_IDX_W-1:0];
        end
      end
      default: begin
      end
    endcase
    r.occ = shadow_fill[dhoat_pkg::OCC_W-1:0];
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_bad(input string what, input logic [dhoat_pkg::WORD_W-1:0] want,
                          input logic [dhoat_pkg::WORD_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s, word %0d: expected %0h, got %0h", what, answers_seen, want, got);
  endtask

  // request driver
  always @(negedge clk) begin : drive_req
    table_req_t t;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && words_taken != words_issued) begin
    end else if (send_gap != 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (requests_q.size() != 0) begin
      t = requests_q.pop_front();
      opcode <= t.op;
      key <= t.k;
      value <= t.v;
      hash1 <= t.h1;
      hash2 <= t.h2;
      in_valid <= 1'b1;
      words_issued <= words_issued + 1;
      send_gap <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // monitor: predict on accept, check on result
  always @(posedge clk) begin : watch
    table_req_t t;
    table_answer_t got, want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        t = '{opcode, key, value, hash1, hash2};
        answers_due.push_back(table_answer(t));
        words_taken <= words_taken + 1;
      end
      if (out_valid && out_ready) begin
        got = '{status, found_value, slot_index, occupancy};
        if (answers_due.size() == 0) begin
          note_bad("unexpected word", '0, got.status);
        end else begin
          want = answers_due.pop_front();
          if (got.status !== want.status) note_bad("status", want.status, got.status);
          if (got.found !== want.found) note_bad("found_value", want.found, got.found);
          if (got.slot !== want.slot) note_bad("slot_index", want.slot, got.slot);
          if (got.occ !== want.occ) note_bad("occupancy", want.occ, got.occ);
        end
        answers_seen++;
      end
    end
  end

  task automatic queue_req(input logic [dhoat_pkg::OPCODE_W-1:0] op,
                           input logic [dhoat_pkg::WORD_W-1:0] k, v, h1, h2);
    table_req_t t;
    t = '{op, k, v, h1, h2};
    requests_q.push_back(t);
  endtask

  task automatic settle(input int unsigned tail);
    while (requests_q.size() != 0 || words_taken != words_issued || answers_due.size() != 0)
      @(posedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_span(input logic [dhoat_pkg::CFG_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    span_reg = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [dhoat_pkg::WORD_W-1:0] pick_hash(input int unsigned lo_max);
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, lo_max);
    return $urandom;
  endfunction

  task automatic refresh_pool(input int unsigned n);
    int unsigned j;
    for (int unsigned i = 0; i < n; i++) begin
      j = (n >= POOL_N) ? i : $urandom_range(0, POOL_N - 1);
      pool_key[j] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom;
      pool_h1[j] = pick_hash(15);
      pool_h2[j] = pick_hash(4);
    end
  endtask

  function automatic logic [dhoat_pkg::OPCODE_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return dhoat_pkg::OP_INSERT;
    if (r < 70) return dhoat_pkg::OP_REMOVE;
    return dhoat_pkg::OP_LOOKUP;
  endfunction

  task automatic queue_random_req();
    int unsigned r, j;
    logic [dhoat_pkg::OPCODE_W-1:0] op;
    r = $urandom_range(0, 99);
    j = $urandom_range(0, POOL_N - 1);
    op = pick_op();
    if (r < 85) queue_req(op, pool_key[j], $urandom, pool_h1[j], pool_h2[j]);
    else if (r < 90) queue_req(dhoat_pkg::OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
    else if (r < 95) queue_req(op, pool_key[j], $urandom, $urandom, $urandom);
    else queue_req(op, $urandom, $urandom, $urandom, $urandom);
  endtask

  // remove every used slot in reach by starting the probe right on it
  task automatic clear_reachable();
    int unsigned p;
    p = clamp_span(span_reg);
    for (int unsigned s = 0; s < p; s++)
      if (shadow_mark[s] == dhoat_pkg::MARK_USED)
        queue_req(dhoat_pkg::OP_REMOVE, shadow_key[s], $urandom, s, $urandom);
  endtask

  function automatic logic [dhoat_pkg::CFG_W-1:0] planned_span(input int ph);
    int unsigned r;
    case (ph)
      0: return 11'd1024;
      1: return 11'd1;
      2: return 11'd2;
      3: return 11'd7;
      4: return 11'd31;
      5: return 11'd1025;
      6: return 11'd5;
      7: return 11'd200;
      default: begin
        r = $urandom_range(0, 9);
        if (r < 4) return dhoat_pkg::CFG_W'($urandom_range(1, 16));
        if (r < 8) return dhoat_pkg::CFG_W'($urandom_range(17, 300));
        return dhoat_pkg::CFG_W'($urandom_range(301, 2047));
      end
    endcase
  endfunction

  initial begin : stimulus
    logic [dhoat_pkg::WORD_W-1:0] k0, k1, k2;
    logic [dhoat_pkg::CFG_W-1:0] next_span;
    k0 = '1;
    k1 = '0;
    k2 = 32'h8000_0001;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table, duplicate, exhausted walk, wrap, vacated skip and reuse
    queue_req(dhoat_pkg::OP_LOOKUP, k0, '0, '1, '1);
    queue_req(dhoat_pkg::OP_REMOVE, k0, '0, '1, '1);
    queue_req(dhoat_pkg::OP_INSERT, k0, '1, '1, '1);
    queue_req(dhoat_pkg::OP_INSERT, k0, 32'd5, '1, '1);
    queue_req(dhoat_pkg::OP_LOOKUP, k0, '0, '1, '1);
    queue_req(dhoat_pkg::OP_INSERT, k1, '0, 32'h3ff, '0);
    queue_req(dhoat_pkg::OP_INSERT, k1, 32'h1234_5678, 32'h7ff, 32'd1);
    queue_req(dhoat_pkg::OP_LOOKUP, k1, '0, 32'h3ff, 32'd1);
    queue_req(dhoat_pkg::OP_REMOVE, k0, '0, '1, '1);
    queue_req(dhoat_pkg::OP_LOOKUP, k1, '0, 32'h3ff, 32'd1);
    queue_req(dhoat_pkg::OP_LOOKUP, k0, '0, '1, '1);
    queue_req(dhoat_pkg::OP_INSERT, k2, 32'ha5a5_a5a5, 32'h3ff, 32'd1);
    queue_req(dhoat_pkg::OP_UNUSED, k2, '1, 32'h3ff, 32'd1);
    queue_req(dhoat_pkg::OP_REMOVE, k1, '0, 32'd5, '0);
    queue_req(dhoat_pkg::OP_LOOKUP, k2, '0, 32'h8000_03ff, 32'h0000_0401);
    settle(4);

    // span of zero acts as one, table full with span below count
    write_span(11'd0);
    queue_req(dhoat_pkg::OP_INSERT, k0, 32'd7, '0, '0);
    queue_req(dhoat_pkg::OP_LOOKUP, k1, '0, $urandom, $urandom);
    queue_req(dhoat_pkg::OP_REMOVE, k1, '0, $urandom, $urandom);
    queue_req(dhoat_pkg::OP_INSERT, k0, 32'd7, '0, '0);
    queue_req(dhoat_pkg::OP_LOOKUP, k1, '0, '0, '0);
    settle(4);

    // span above table size, entries beyond the old span still there
    write_span(11'd2047);
    queue_req(dhoat_pkg::OP_LOOKUP, k2, '0, 32'h3ff, 32'd1);
    queue_req(dhoat_pkg::OP_INSERT, k0, '0, '1, '1);
    queue_req(dhoat_pkg::OP_REMOVE, k2, '0, 32'h3ff, 32'd1);
    queue_req(dhoat_pkg::OP_REMOVE, k0, '0, '1, '1);

    refresh_pool(POOL_N);
    for (int ph = 0; ph < PHASES; ph++) begin
      next_span = planned_span(ph);
      settle(4);
      if (clamp_span(next_span) < clamp_span(span_reg) && ph % 3 != 2) begin
        clear_reachable();
        settle(4);
      end
      write_span(next_span);
      quiet = (ph % 5 == 3);
      refresh_pool(8);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        queue_random_req();
        if (ph % 4 == 1 && i == PHASE_WORDS / 2) settle(0);
      end
    end

    settle(100);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("FAIL");
    $finish;
  end

endmodule
